// ===== rtl/core/chgs_pkg.sv =====
// Shared types and constants for the Graham scan convex hull block.
// Used by the hull sequencer, the turn unit and the checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chgs_pkg;

    // default geometry of the point store and coordinates
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    // fixed widths of the payload fields
    localparam int FIELD_W = 16;
    localparam int VIDX_W  = 6;

    // smallest set that has a hull
    localparam int MIN_POINTS = 3;

    // result of the turn unit: sign of the cross product
    typedef struct packed {
        logic done;
        logic left;
        logic zero;
    } turn_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/convex_hull_graham_scan.sv =====
// Operation: points are taken while the block is idle; the item marked last then
// occupies the block for the anchor and list passes, the insertion sort (up to
// n*n/2 compares), the filter and the scan, and then for the output of each hull
// vertex with its handshake. The shared turn unit and the single RAM read ports
// pace these steps. Reset clears control state; the RAMs are not cleared.
// Top level of the convex hull block; uses chgs_pkg, chgs_ram and chgs_turn.
`timescale 1ns / 1ps
`default_nettype none

module convex_hull_graham_scan #(
    parameter int MAX_POINTS = chgs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chgs_pkg::COORD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [chgs_pkg::FIELD_W-1:0] point_x,
    input  wire logic signed [chgs_pkg::FIELD_W-1:0] point_y,
    input  wire logic                                last_point,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [chgs_pkg::FIELD_W-1:0]      hull_x,
    output logic signed [chgs_pkg::FIELD_W-1:0]      hull_y,
    output logic [chgs_pkg::VIDX_W-1:0]              vertex_index,
    output logic                                     last_vertex,
    output logic                                     too_few_points,
    output logic                                     points_dropped
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int FW = chgs_pkg::FIELD_W;
    localparam int VW = chgs_pkg::VIDX_W;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ERR_W,
        S_ANC_RD,
        S_ANC_CHK,
        S_LST_RD,
        S_LST_CHK,
        S_SO_I,
        S_SO_V1,
        S_SO_V2,
        S_SO_J,
        S_SO_U1,
        S_SO_U2,
        S_SO_US,
        S_SO_UW,
        S_DD_I0,
        S_DD_A1,
        S_DD_A2,
        S_DD_N,
        S_DD_B1,
        S_DD_B2,
        S_DD_S,
        S_DD_W,
        S_SC_INIT,
        S_SC_I,
        S_SC_B1,
        S_SC_B2,
        S_SC_CHK,
        S_SC_W,
        S_SC_O1,
        S_SC_O2,
        S_EM_I,
        S_EM_1
    } state_t;

    // substeps of the emission step, with their own codes
    typedef enum logic [1:0] {
        E_NONE,
        E_LOAD,
        E_WAIT
    } emit_t;

    state_t                state_reg;
    emit_t                 emit_reg;
    logic [CW-1:0]         cnt_reg, i_reg, j_reg, k_reg, w_reg, h_reg;
    logic                  ovf_reg;
    logic [IW-1:0]         anc_idx_reg;
    logic signed [CB-1:0]  anc_x_reg, anc_y_reg;
    logic signed [CB-1:0]  o_x_reg, o_y_reg, a_x_reg, a_y_reg, b_x_reg, b_y_reg;
    logic [IW-1:0]         a_idx_reg, b_idx_reg;
    logic signed [FW-1:0]  hull_x_reg, hull_y_reg;
    logic [VW-1:0]         vidx_reg;
    logic                  last_reg, few_reg, drop_reg, out_valid_reg;

    // RAM ports
    logic                  pts_we, ord_we, stk_we;
    logic [IW-1:0]         pts_raddr, ord_raddr, ord_waddr, stk_raddr, stk_waddr;
    logic [IW-1:0]         ord_wdata, stk_wdata;
    logic [2*CB-1:0]       pts_wdata, pts_rdata;
    logic [IW-1:0]         ord_rdata, stk_rdata;

    // input coordinates: low CB bits of the zero-extended field
    logic [31:0]           raw_x, raw_y;
    logic signed [CB-1:0]  in_cx, in_cy, rd_x, rd_y;
    logic [31:0]           ext_x, ext_y;

    // turn unit operands and helpers
    logic signed [DW-1:0]  adx, ady, bdx, bdy;
    logic [DW-1:0]         abs_adx, abs_ady, abs_bdx, abs_bdy;
    logic [DW:0]           l1_a, l1_b;
    logic                  turn_start;
    chgs_pkg::turn_res_t   tres;
    logic                  in_acc, store_ok, prec;
    logic [CW-1:0]         n_next, jm1, ip1, hm3;

    assign raw_x = {16'b0, point_x};
    assign raw_y = {16'b0, point_y};
    assign in_cx = raw_x[CB-1:0];
    assign in_cy = raw_y[CB-1:0];
    assign rd_x  = pts_rdata[2*CB-1:CB];
    assign rd_y  = pts_rdata[CB-1:0];
    assign ext_x = {{(32-CB){rd_x[CB-1]}}, rd_x};
    assign ext_y = {{(32-CB){rd_y[CB-1]}}, rd_y};

    assign in_acc   = in_valid && in_ready;
    assign store_ok = (cnt_reg < CW'(MAX_POINTS));
    assign n_next   = store_ok ? (cnt_reg + 1'b1) : cnt_reg;
    assign jm1      = j_reg - 1'b1;
    assign ip1      = i_reg + 1'b1;
    assign hm3      = h_reg - CW'(3);

    // cross product operands relative to o
    assign adx = $signed({a_x_reg[CB-1], a_x_reg}) - $signed({o_x_reg[CB-1], o_x_reg});
    assign ady = $signed({a_y_reg[CB-1], a_y_reg}) - $signed({o_y_reg[CB-1], o_y_reg});
    assign bdx = $signed({b_x_reg[CB-1], b_x_reg}) - $signed({o_x_reg[CB-1], o_x_reg});
    assign bdy = $signed({b_y_reg[CB-1], b_y_reg}) - $signed({o_y_reg[CB-1], o_y_reg});

    // distance along a common direction: the l1 norm orders it exactly
    assign abs_adx = adx[DW-1] ? DW'(-adx) : DW'(adx);
    assign abs_ady = ady[DW-1] ? DW'(-ady) : DW'(ady);
    assign abs_bdx = bdx[DW-1] ? DW'(-bdx) : DW'(bdx);
    assign abs_bdy = bdy[DW-1] ? DW'(-bdy) : DW'(bdy);
    assign l1_a    = {1'b0, abs_adx} + {1'b0, abs_ady};
    assign l1_b    = {1'b0, abs_bdx} + {1'b0, abs_bdy};
    assign prec    = tres.left || (tres.zero && (l1_a < l1_b));

    assign turn_start = (state_reg == S_SO_US) || (state_reg == S_DD_S) ||
                        (state_reg == S_SC_CHK && h_reg >= CW'(2));

    chgs_turn #(.DW(DW)) u_turn (
        .clk   (clk),
        .rst_n (rst_n),
        .start (turn_start),
        .op_a  (adx),
        .op_b  (bdy),
        .op_c  (bdx),
        .op_d  (ady),
        .res   (tres)
    );

    // point store
    assign pts_we    = in_acc && store_ok;
    assign pts_wdata = {in_cx, in_cy};

    chgs_ram #(.WIDTH(2*CB), .DEPTH(MAX_POINTS)) u_pts (
        .clk   (clk),
        .we    (pts_we),
        .waddr (cnt_reg[IW-1:0]),
        .wdata (pts_wdata),
        .raddr (pts_raddr),
        .rdata (pts_rdata)
    );

    chgs_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_ord (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    chgs_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_stk (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // read addresses by step
    always_comb
    begin
        pts_raddr = '0;
        ord_raddr = '0;
        stk_raddr = '0;
        case (state_reg)
            S_ANC_RD, S_LST_RD:                     pts_raddr = i_reg[IW-1:0];
            S_SO_V1, S_SO_U1, S_DD_A1, S_DD_B1,
            S_SC_B1:                                pts_raddr = ord_rdata;
            S_SC_O1, S_EM_1:                        pts_raddr = stk_rdata;
            S_SO_I, S_SC_I:                         ord_raddr = i_reg[IW-1:0];
            S_SO_J:                                 ord_raddr = jm1[IW-1:0];
            S_DD_N:                                 ord_raddr = ip1[IW-1:0];
            S_SC_W:                                 stk_raddr = hm3[IW-1:0];
            S_EM_I:                                 stk_raddr = i_reg[IW-1:0];
            default:                                pts_raddr = '0;
        endcase
    end

    // order and stack writes by step
    always_comb
    begin
        ord_we    = 1'b0;
        ord_waddr = '0;
        ord_wdata = a_idx_reg;
        stk_we    = 1'b0;
        stk_waddr = h_reg[IW-1:0];
        stk_wdata = b_idx_reg;
        case (state_reg)
            S_LST_CHK:
            begin
                ord_we    = (i_reg[IW-1:0] != anc_idx_reg) &&
                            !(rd_x == anc_x_reg && rd_y == anc_y_reg);
                ord_waddr = k_reg[IW-1:0];
                ord_wdata = i_reg[IW-1:0];
            end
            S_SO_J:
            begin
                ord_we    = (j_reg == '0);
                ord_waddr = j_reg[IW-1:0];
            end
            S_SO_UW:
            begin
                ord_we    = tres.done;
                ord_waddr = j_reg[IW-1:0];
                ord_wdata = prec ? b_idx_reg : a_idx_reg;
            end
            S_DD_N:
            begin
                ord_we    = !(ip1 < k_reg);
                ord_waddr = w_reg[IW-1:0];
            end
            S_DD_W:
            begin
                ord_we    = tres.done && !tres.zero;
                ord_waddr = w_reg[IW-1:0];
            end
            S_SC_INIT:
            begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = anc_idx_reg;
            end
            S_SC_CHK:  stk_we = (h_reg < CW'(2));
            S_SC_W:    stk_we = tres.done && tres.left;
            default:   ord_we = 1'b0;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            emit_reg      <= E_NONE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            anc_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            w_reg         <= '0;
            h_reg         <= '0;
        end
        else
        begin
            case (state_reg)
                // loading
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        cnt_reg <= n_next;
                        if (!store_ok)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (last_point)
                        begin
                            if (n_next < CW'(chgs_pkg::MIN_POINTS))
                            begin
                                hull_x_reg    <= '0;
                                hull_y_reg    <= '0;
                                vidx_reg      <= '0;
                                last_reg      <= 1'b1;
                                few_reg       <= 1'b1;
                                drop_reg      <= ovf_reg;
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_ERR_W;
                            end
                            else
                            begin
                                i_reg     <= '0;
                                state_reg <= S_ANC_RD;
                            end
                        end
                    end
                end
                S_ERR_W:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        cnt_reg       <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                // anchor search
                S_ANC_RD:
                begin
                    if (i_reg == cnt_reg)
                    begin
                        i_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= S_LST_RD;
                    end
                    else
                    begin
                        state_reg <= S_ANC_CHK;
                    end
                end
                S_ANC_CHK:
                begin
                    if (i_reg == '0 || rd_y < anc_y_reg ||
                        (rd_y == anc_y_reg && rd_x < anc_x_reg))
                    begin
                        anc_idx_reg <= i_reg[IW-1:0];
                        anc_x_reg   <= rd_x;
                        anc_y_reg   <= rd_y;
                    end
                    i_reg     <= ip1;
                    state_reg <= S_ANC_RD;
                end
                // list of points distinct from the anchor
                S_LST_RD:
                begin
                    if (i_reg == cnt_reg)
                    begin
                        i_reg     <= CW'(1);
                        o_x_reg   <= anc_x_reg;
                        o_y_reg   <= anc_y_reg;
                        state_reg <= S_SO_I;
                    end
                    else
                    begin
                        state_reg <= S_LST_CHK;
                    end
                end
                S_LST_CHK:
                begin
                    if ((i_reg[IW-1:0] != anc_idx_reg) &&
                        !(rd_x == anc_x_reg && rd_y == anc_y_reg))
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                    i_reg     <= ip1;
                    state_reg <= S_LST_RD;
                end
                // insertion sort by angle then distance
                S_SO_I:
                begin
                    if (i_reg >= k_reg)
                    begin
                        state_reg <= S_DD_I0;
                    end
                    else
                    begin
                        state_reg <= S_SO_V1;
                    end
                end
                S_SO_V1:
                begin
                    a_idx_reg <= ord_rdata;
                    state_reg <= S_SO_V2;
                end
                S_SO_V2:
                begin
                    a_x_reg   <= rd_x;
                    a_y_reg   <= rd_y;
                    j_reg     <= i_reg;
                    state_reg <= S_SO_J;
                end
                S_SO_J:
                begin
                    if (j_reg == '0)
                    begin
                        i_reg     <= ip1;
                        state_reg <= S_SO_I;
                    end
                    else
                    begin
                        state_reg <= S_SO_U1;
                    end
                end
                S_SO_U1:
                begin
                    b_idx_reg <= ord_rdata;
                    state_reg <= S_SO_U2;
                end
                S_SO_U2:
                begin
                    b_x_reg   <= rd_x;
                    b_y_reg   <= rd_y;
                    state_reg <= S_SO_US;
                end
                S_SO_US:  state_reg <= S_SO_UW;
                S_SO_UW:
                begin
                    if (tres.done)
                    begin
                        if (prec)
                        begin
                            j_reg     <= jm1;
                            state_reg <= S_SO_J;
                        end
                        else
                        begin
                            i_reg     <= ip1;
                            state_reg <= S_SO_I;
                        end
                    end
                end
                // keep only the farthest point of each direction
                S_DD_I0:
                begin
                    i_reg <= '0;
                    w_reg <= '0;
                    if (k_reg == '0)
                    begin
                        state_reg <= S_SC_INIT;
                    end
                    else
                    begin
                        state_reg <= S_DD_A1;
                    end
                end
                S_DD_A1:
                begin
                    a_idx_reg <= ord_rdata;
                    state_reg <= S_DD_A2;
                end
                S_DD_A2:
                begin
                    a_x_reg   <= rd_x;
                    a_y_reg   <= rd_y;
                    state_reg <= S_DD_N;
                end
                S_DD_N:
                begin
                    if (ip1 < k_reg)
                    begin
                        state_reg <= S_DD_B1;
                    end
                    else
                    begin
                        w_reg     <= w_reg + 1'b1;
                        state_reg <= S_SC_INIT;
                    end
                end
                S_DD_B1:
                begin
                    b_idx_reg <= ord_rdata;
                    state_reg <= S_DD_B2;
                end
                S_DD_B2:
                begin
                    b_x_reg   <= rd_x;
                    b_y_reg   <= rd_y;
                    state_reg <= S_DD_S;
                end
                S_DD_S:   state_reg <= S_DD_W;
                S_DD_W:
                begin
                    if (tres.done)
                    begin
                        if (!tres.zero)
                        begin
                            w_reg <= w_reg + 1'b1;
                        end
                        a_idx_reg <= b_idx_reg;
                        a_x_reg   <= b_x_reg;
                        a_y_reg   <= b_y_reg;
                        i_reg     <= ip1;
                        state_reg <= S_DD_N;
                    end
                end
                // stack scan, top of stack in a, the entry below in o
                S_SC_INIT:
                begin
                    a_x_reg   <= anc_x_reg;
                    a_y_reg   <= anc_y_reg;
                    h_reg     <= CW'(1);
                    i_reg     <= '0;
                    state_reg <= S_SC_I;
                end
                S_SC_I:
                begin
                    if (i_reg >= w_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_EM_I;
                    end
                    else
                    begin
                        state_reg <= S_SC_B1;
                    end
                end
                S_SC_B1:
                begin
                    b_idx_reg <= ord_rdata;
                    state_reg <= S_SC_B2;
                end
                S_SC_B2:
                begin
                    b_x_reg   <= rd_x;
                    b_y_reg   <= rd_y;
                    state_reg <= S_SC_CHK;
                end
                S_SC_CHK:
                begin
                    if (h_reg >= CW'(2))
                    begin
                        state_reg <= S_SC_W;
                    end
                    else
                    begin
                        h_reg     <= h_reg + 1'b1;
                        o_x_reg   <= a_x_reg;
                        o_y_reg   <= a_y_reg;
                        a_x_reg   <= b_x_reg;
                        a_y_reg   <= b_y_reg;
                        i_reg     <= ip1;
                        state_reg <= S_SC_I;
                    end
                end
                S_SC_W:
                begin
                    if (tres.done)
                    begin
                        if (tres.left)
                        begin
                            h_reg     <= h_reg + 1'b1;
                            o_x_reg   <= a_x_reg;
                            o_y_reg   <= a_y_reg;
                            a_x_reg   <= b_x_reg;
                            a_y_reg   <= b_y_reg;
                            i_reg     <= ip1;
                            state_reg <= S_SC_I;
                        end
                        else
                        begin
                            h_reg   <= h_reg - 1'b1;
                            a_x_reg <= o_x_reg;
                            a_y_reg <= o_y_reg;
                            if (h_reg >= CW'(3))
                            begin
                                state_reg <= S_SC_O1;
                            end
                            else
                            begin
                                state_reg <= S_SC_CHK;
                            end
                        end
                    end
                end
                S_SC_O1:  state_reg <= S_SC_O2;
                S_SC_O2:
                begin
                    o_x_reg   <= rd_x;
                    o_y_reg   <= rd_y;
                    state_reg <= S_SC_CHK;
                end
                // emission of the hull vertices
                S_EM_I:
                begin
                    emit_reg  <= E_NONE;
                    state_reg <= S_EM_1;
                end
                S_EM_1:
                begin
                    case (emit_reg)
                        E_NONE:
                        begin
                            emit_reg <= E_LOAD;
                        end
                        E_LOAD:
                        begin
                            hull_x_reg    <= ext_x[FW-1:0];
                            hull_y_reg    <= ext_y[FW-1:0];
                            vidx_reg      <= VW'(i_reg);
                            last_reg      <= (ip1 == h_reg);
                            few_reg       <= 1'b0;
                            drop_reg      <= ovf_reg;
                            out_valid_reg <= 1'b1;
                            emit_reg      <= E_WAIT;
                        end
                        E_WAIT:
                        begin
                            if (out_ready)
                            begin
                                out_valid_reg <= 1'b0;
                                emit_reg      <= E_NONE;
                                if (ip1 == h_reg)
                                begin
                                    cnt_reg   <= '0;
                                    ovf_reg   <= 1'b0;
                                    state_reg <= S_IDLE;
                                end
                                else
                                begin
                                    i_reg     <= ip1;
                                    state_reg <= S_EM_I;
                                end
                            end
                        end
                        default:  emit_reg <= E_NONE;
                    endcase
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign hull_x         = hull_x_reg;
    assign hull_y         = hull_y_reg;
    assign vertex_index   = vidx_reg;
    assign last_vertex    = last_reg;
    assign too_few_points = few_reg;
    assign points_dropped = drop_reg;

endmodule

`default_nettype wire

// ===== rtl/core/chgs_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module chgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/chgs_turn.sv =====
// Shared turn unit: sign of a*b - c*d from two products taken in turn on one multiplier.
// Depends on chgs_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module chgs_turn #(
    parameter int DW = 17
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [DW-1:0] op_a,
    input  wire logic signed [DW-1:0] op_b,
    input  wire logic signed [DW-1:0] op_c,
    input  wire logic signed [DW-1:0] op_d,
    output chgs_pkg::turn_res_t       res
);

    typedef enum logic [1:0] {
        T_IDLE,
        T_MUL1,
        T_MUL2,
        T_DONE
    } tstate_t;

    tstate_t                 state_reg;
    logic signed [DW-1:0]    a_reg, b_reg, c_reg, d_reg;
    logic signed [2*DW-1:0]  p_reg, q_reg;
    logic signed [DW-1:0]    mul_x, mul_y;
    logic signed [2*DW-1:0]  mul_p;

    // one multiplier, operands picked by the step
    assign mul_x = (state_reg == T_MUL1) ? a_reg : c_reg;
    assign mul_y = (state_reg == T_MUL1) ? b_reg : d_reg;
    assign mul_p = mul_x * mul_y;

    // sequencing of the two products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
        end
        else
        begin
            case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= T_MUL1;
                    end
                end
                T_MUL1:  state_reg <= T_MUL2;
                T_MUL2:  state_reg <= T_DONE;
                T_DONE:  state_reg <= T_IDLE;
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    // operand and product registers
    always_ff @(posedge clk)
    begin
        if (state_reg == T_IDLE && start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
            c_reg <= op_c;
            d_reg <= op_d;
        end
        if (state_reg == T_MUL1)
        begin
            p_reg <= mul_p;
        end
        if (state_reg == T_MUL2)
        begin
            q_reg <= mul_p;
        end
    end

    // compare of the two products
    assign res.done = (state_reg == T_DONE);
    assign res.left = (p_reg > q_reg);
    assign res.zero = (p_reg == q_reg);

endmodule

`default_nettype wire

// ===== rtl/core/chgs_chk.sv =====
// Port-level checker for the convex hull block, bound to the top level.
// Depends on chgs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module chgs_chk (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_ready,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic signed [chgs_pkg::FIELD_W-1:0] hull_x,
    input wire logic signed [chgs_pkg::FIELD_W-1:0] hull_y,
    input wire logic [chgs_pkg::VIDX_W-1:0]         vertex_index,
    input wire logic                                last_vertex,
    input wire logic                                too_few_points
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hull_x) && $stable(hull_y)
            && $stable(vertex_index))
        else $error("result changed while stalled");

    // no new item is taken while results are still being delivered
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready during emission");

    // the error result is a lone zero item
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_few_points |-> last_vertex && hull_x == '0 && hull_y == '0
            && vertex_index == '0)
        else $error("malformed error result");

    // the block is free again once the final vertex has gone
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_vertex |=> in_ready)
        else $error("not ready after final vertex");

endmodule

bind convex_hull_graham_scan chgs_chk u_chgs_chk (.*);

`default_nettype wire
